// ----- rtl/quaternion_to_euler_angles_macros.svh -----
// Assertion macros shared by the quaternion to Euler angle block.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define QTE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/qte_pkg.sv -----
// Shared widths, types and the CORDIC angle table of the quaternion to Euler angle block.
package qte_pkg;

	// Field widths of the stream payloads.
	localparam int QW = 16;
	localparam int OW = 15;
	localparam int IN_TDATA_W = 4 * QW;
	localparam int OUT_TDATA_W = ((3 * OW + 7) / 8) * 8;

	// Front arithmetic: ratio operands, saturated asin argument and square root.
	localparam int RW = 36;
	localparam int SFRAC = 28;
	localparam int SW = SFRAC + 2;
	localparam int SQW = 2 * SW;
	localparam int SQN = SFRAC + 1;

	// Back arithmetic: normalization target, CORDIC datapath and angle accumulator.
	localparam int NORM_BIT = 40;
	localparam int NW = NORM_BIT + 1;
	localparam int CW = 45;
	localparam int AW = 34;
	localparam int ACC_FRAC = 30;
	localparam longint HALF_PI_ACC = 64'sd1686629713;

	// Queue between front and back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	// Defaults of the top-level parameters.
	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 13;

	// One atan request, already classified and folded to a nonnegative x.
	typedef struct packed {
		logic zero_den;
		logic num_pos;
		logic num_neg;
		logic signed [RW-1:0] cx;
		logic signed [RW-1:0] cy;
	} qte_atan_t;

	// One queued request: the three angles of one quaternion.
	typedef struct packed {
		qte_atan_t roll;
		qte_atan_t pitch;
		qte_atan_t yaw;
	} qte_item_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
		logic [FIFO_CW-1:0] count;
	} qte_fifo_st_t;

	// atan(2^-i) scaled by 2^30, rounded to nearest.
	function automatic logic signed [AW-1:0] atan_tab(input int i);
		logic signed [AW-1:0] v;
		unique case (i)
			0: v = AW'(843314857);
			1: v = AW'(497837829);
			2: v = AW'(263043837);
			3: v = AW'(133525159);
			4: v = AW'(67021687);
			5: v = AW'(33543516);
			6: v = AW'(16775851);
			7: v = AW'(8388437);
			8: v = AW'(4194283);
			9: v = AW'(2097149);
			10: v = AW'(1048576);
			11: v = AW'(524288);
			12: v = AW'(262144);
			13: v = AW'(131072);
			14: v = AW'(65536);
			15: v = AW'(32768);
			16: v = AW'(16384);
			17: v = AW'(8192);
			18: v = AW'(4096);
			19: v = AW'(2048);
			20: v = AW'(1024);
			21: v = AW'(512);
			22: v = AW'(256);
			23: v = AW'(128);
			24: v = AW'(64);
			25: v = AW'(32);
			26: v = AW'(16);
			27: v = AW'(8);
			28: v = AW'(4);
			29: v = AW'(2);
			30: v = AW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/qte_fifo.sv -----
// Short request queue between the front and the back of the block.
module qte_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  qte_pkg::qte_item_t    push_data,
	input  logic                  pop,
	output qte_pkg::qte_item_t    pop_data,
	output qte_pkg::qte_fifo_st_t status
);
	import qte_pkg::*;

	qte_item_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_CW-1:0] cnt_q;

	// Storage; the caller never pushes when full nor pops when empty.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign pop_data = mem_q[rd_q];
	assign status.full = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign status.count = cnt_q;
endmodule

// ----- rtl/qte_front.sv -----
// Front part: products, ratio terms, the pitch square root and request classification.
module qte_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [qte_pkg::IN_TDATA_W-1:0] s_tdata, // quat_w, quat_x, quat_y, quat_z
	input  qte_pkg::qte_fifo_st_t         fifo_st,
	output logic                          push,
	output qte_pkg::qte_item_t            push_data
);
	import qte_pkg::*;

	localparam int FL = 3 + SQN;
	localparam logic signed [RW-1:0] S_ONE = RW'(longint'(1) << SFRAC);
	localparam logic [SQW-1:0] SQ_ONE = SQW'(longint'(1) << (2 * SFRAC));

	typedef struct packed {
		logic signed [RW-1:0] roll_n;
		logic signed [RW-1:0] roll_d;
		logic signed [RW-1:0] yaw_n;
		logic signed [RW-1:0] yaw_d;
		logic signed [SW-1:0] pit_s;
	} qte_ratio_t;

	logic adv;
	logic [FL-1:0] vld_q;
	logic signed [QW-1:0] qw, qx, qy, qz;
	logic signed [2*QW-1:0] p_ww_s1, p_xx_s1, p_yy_s1, p_zz_s1, p_xy_s1;
	logic signed [2*QW-1:0] p_wz_s1, p_yz_s1, p_xw_s1, p_xz_s1, p_yw_s1;
	logic signed [RW-1:0] s_raw;
	qte_ratio_t rat_s2;
	logic signed [SQW-1:0] sq;
	qte_ratio_t rat_q [0:SQN];
	logic [SQW-1:0] rem_q [0:SQN];
	logic [SQN-1:0] root_q [0:SQN];

	// The whole front moves together unless its last request waits on a full queue.
	assign adv = !vld_q[FL-1] || !fifo_st.full;
	assign s_tready = adv;
	assign push = vld_q[FL-1] && !fifo_st.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[FL-2:0], s_tvalid};
		end
	end

	assign qw = signed'(s_tdata[QW-1:0]);
	assign qx = signed'(s_tdata[2*QW-1:QW]);
	assign qy = signed'(s_tdata[3*QW-1:2*QW]);
	assign qz = signed'(s_tdata[4*QW-1:3*QW]);

	// Stage one: all pairwise products, exact in Q28.
	always_ff @(posedge clk) begin
		if (adv) begin
			p_ww_s1 <= qw * qw;
			p_xx_s1 <= qx * qx;
			p_yy_s1 <= qy * qy;
			p_zz_s1 <= qz * qz;
			p_xy_s1 <= qx * qy;
			p_wz_s1 <= qw * qz;
			p_yz_s1 <= qy * qz;
			p_xw_s1 <= qx * qw;
			p_xz_s1 <= qx * qz;
			p_yw_s1 <= qy * qw;
		end
	end

	// Stage two: numerators, denominators and the clamped asin argument.
	assign s_raw = (RW'(p_yw_s1) - RW'(p_xz_s1)) <<< 1;

	always_ff @(posedge clk) begin
		if (adv) begin
			rat_s2.yaw_n <= (RW'(p_xy_s1) + RW'(p_wz_s1)) <<< 1;
			rat_s2.yaw_d <= RW'(p_ww_s1) + RW'(p_xx_s1) - RW'(p_yy_s1) - RW'(p_zz_s1);
			rat_s2.roll_n <= (RW'(p_yz_s1) + RW'(p_xw_s1)) <<< 1;
			rat_s2.roll_d <= RW'(p_ww_s1) - RW'(p_xx_s1) - RW'(p_yy_s1) + RW'(p_zz_s1);
			if (s_raw > S_ONE) begin
				rat_s2.pit_s <= SW'(S_ONE);
			end else if (s_raw < -S_ONE) begin
				rat_s2.pit_s <= SW'(-S_ONE);
			end else begin
				rat_s2.pit_s <= SW'(s_raw);
			end
		end
	end

	// Stage three: radicand 1 - s^2 for the cosine of pitch.
	assign sq = rat_s2.pit_s * rat_s2.pit_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			rat_q[0] <= rat_s2;
			rem_q[0] <= SQ_ONE - $unsigned(sq);
			root_q[0] <= '0;
		end
	end

	// Restoring square root, one result bit per stage from the top.
	for (genvar k = 1; k <= SQN; k++) begin : g_sqrt
		localparam int B = SQN - k;
		logic [SQW-1:0] trial;

		assign trial = (SQW'(root_q[k-1]) << (B + 1)) + (SQW'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (adv) begin
				rat_q[k] <= rat_q[k-1];
				if (rem_q[k-1] >= trial) begin
					rem_q[k] <= rem_q[k-1] - trial;
					root_q[k] <= root_q[k-1] | (SQN'(1) << B);
				end else begin
					rem_q[k] <= rem_q[k-1];
					root_q[k] <= root_q[k-1];
				end
			end
		end
	end

	// Classify each ratio: flag a zero denominator and fold the denominator positive.
	function automatic qte_atan_t classify(input logic signed [RW-1:0] n,
	                                       input logic signed [RW-1:0] d);
		qte_atan_t r;
		r.zero_den = (d == '0);
		r.num_pos = !n[RW-1] && (n != '0);
		r.num_neg = n[RW-1];
		r.cx = d[RW-1] ? -d : d;
		r.cy = d[RW-1] ? -n : n;
		return r;
	endfunction

	assign push_data.roll = classify(rat_q[SQN].roll_n, rat_q[SQN].roll_d);
	assign push_data.yaw = classify(rat_q[SQN].yaw_n, rat_q[SQN].yaw_d);
	assign push_data.pitch = classify(RW'(rat_q[SQN].pit_s),
	                                  signed'(RW'({1'b0, root_q[SQN]})));
endmodule

// ----- rtl/qte_lane.sv -----
// One vectoring CORDIC lane: normalize, rotate, round and saturate one angle.
module qte_lane #(
	parameter int ITER = qte_pkg::CORDIC_ITERATIONS_DEF,
	parameter int AF = qte_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  qte_pkg::qte_atan_t      req,
	output logic [qte_pkg::OW-1:0]  angle
);
	import qte_pkg::*;

	localparam int NS = 6;
	localparam int SH = ACC_FRAC - AF;
	localparam logic signed [AW-1:0] RND = AW'(longint'(1) << (SH - 1));
	localparam logic signed [AW-1:0] HP = AW'((HALF_PI_ACC + (longint'(1) << (SH - 1))) >>> SH);

	typedef struct packed {
		logic zero_den;
		logic num_pos;
		logic num_neg;
	} qte_flag_t;

	qte_flag_t fl_q [0:NS+ITER];
	logic signed [CW-1:0] nx_q [0:NS];
	logic signed [CW-1:0] ny_q [0:NS];
	logic [NW-1:0] nm_q [0:NS];
	logic signed [CW-1:0] cx_q [0:ITER-1];
	logic signed [CW-1:0] cy_q [0:ITER-1];
	logic signed [AW-1:0] acc_q [0:ITER-1];
	logic [RW-1:0] cy_mag;
	logic signed [AW-1:0] rs;
	logic signed [AW-1:0] sel;
	logic [OW-1:0] angle_q;

	// Entry stage: widen and take the magnitude bound for normalization.
	assign cy_mag = req.cy[RW-1] ? RW'(-req.cy) : RW'(req.cy);

	always_ff @(posedge clk) begin
		if (en) begin
			fl_q[0] <= '{req.zero_den, req.num_pos, req.num_neg};
			nx_q[0] <= CW'(req.cx);
			ny_q[0] <= CW'(req.cy);
			nm_q[0] <= NW'(RW'(req.cx) | cy_mag);
		end
	end

	// Binary normalization: shift by 32, 16, 8, 4, 2, 1 while the bound stays below 2^41.
	for (genvar k = 1; k <= NS; k++) begin : g_norm
		localparam int B = 1 << (NS - k);
		logic fit;

		assign fit = ((nm_q[k-1] >> (NW - B)) == '0);

		always_ff @(posedge clk) begin
			if (en) begin
				fl_q[k] <= fl_q[k-1];
				if (fit) begin
					nx_q[k] <= nx_q[k-1] <<< B;
					ny_q[k] <= ny_q[k-1] <<< B;
					nm_q[k] <= nm_q[k-1] << B;
				end else begin
					nx_q[k] <= nx_q[k-1];
					ny_q[k] <= ny_q[k-1];
					nm_q[k] <= nm_q[k-1];
				end
			end
		end
	end

	// CORDIC micro-rotations, one per stage, driving y toward zero.
	for (genvar j = 0; j < ITER; j++) begin : g_rot
		logic signed [CW-1:0] xi;
		logic signed [CW-1:0] yi;
		logic signed [AW-1:0] ai;

		if (j == 0) begin : g_first
			assign xi = nx_q[NS];
			assign yi = ny_q[NS];
			assign ai = '0;
		end else begin : g_next
			assign xi = cx_q[j-1];
			assign yi = cy_q[j-1];
			assign ai = acc_q[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				fl_q[NS+1+j] <= fl_q[NS+j];
				if (!yi[CW-1]) begin
					cx_q[j] <= xi + (yi >>> j);
					cy_q[j] <= yi - (xi >>> j);
					acc_q[j] <= ai + atan_tab(j);
				end else begin
					cx_q[j] <= xi - (yi >>> j);
					cy_q[j] <= yi + (xi >>> j);
					acc_q[j] <= ai - atan_tab(j);
				end
			end
		end
	end

	// Round half up, saturate to a quarter turn, or take the fixed answer for a zero denominator.
	assign rs = (acc_q[ITER-1] + RND) >>> SH;

	always_comb begin
		if (fl_q[NS+ITER].zero_den) begin
			if (fl_q[NS+ITER].num_pos) begin
				sel = HP;
			end else if (fl_q[NS+ITER].num_neg) begin
				sel = -HP;
			end else begin
				sel = '0;
			end
		end else if (rs > HP) begin
			sel = HP;
		end else if (rs < -HP) begin
			sel = -HP;
		end else begin
			sel = rs;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= sel[OW-1:0];
		end
	end

	assign angle = angle_q;
endmodule

// ----- rtl/qte_back.sv -----
// Back part: three CORDIC lanes fed from the queue, with the result register.
module qte_back #(
	parameter int ITER = qte_pkg::CORDIC_ITERATIONS_DEF,
	parameter int AF = qte_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  qte_pkg::qte_fifo_st_t          fifo_st,
	input  qte_pkg::qte_item_t             pop_data,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [qte_pkg::OUT_TDATA_W-1:0] m_tdata // roll_angle, pitch_angle, yaw_angle
);
	import qte_pkg::*;

	localparam int LAT = ITER + 8;

	logic adv;
	logic [LAT-1:0] vld_q;
	logic [OW-1:0] roll_a, pitch_a, yaw_a;

	// The back moves as one unless a finished result is waiting to be taken.
	assign adv = !vld_q[LAT-1] || m_tready;
	assign pop = adv && !fifo_st.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], !fifo_st.empty};
		end
	end

	qte_lane #(.ITER(ITER), .AF(AF)) u_roll (
		.clk(clk), .en(adv), .req(pop_data.roll), .angle(roll_a)
	);
	qte_lane #(.ITER(ITER), .AF(AF)) u_pitch (
		.clk(clk), .en(adv), .req(pop_data.pitch), .angle(pitch_a)
	);
	qte_lane #(.ITER(ITER), .AF(AF)) u_yaw (
		.clk(clk), .en(adv), .req(pop_data.yaw), .angle(yaw_a)
	);

	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata = {(OUT_TDATA_W - 3 * OW)'(0), yaw_a, pitch_a, roll_a};
endmodule

// ----- rtl/quaternion_to_euler_angles.sv -----
// Throughput: one request per cycle unless stalled; the front pipeline (products, 29-step square
// root) stalls only on a full queue, and the back pipeline (normalizer, one CORDIC stage per
// iteration) only while a finished result waits to be taken; each advances one stage a cycle when it moves.
// A four-entry queue lets the front keep accepting while the back holds a result.
// Reset: arst_n clears all valid bits and queue pointers at once; no clearing pass is needed.
`include "quaternion_to_euler_angles_macros.svh"

// Top level of the quaternion to roll, pitch and yaw block.
module quaternion_to_euler_angles #(
	parameter int CORDIC_ITERATIONS = qte_pkg::CORDIC_ITERATIONS_DEF,
	parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [qte_pkg::IN_TDATA_W-1:0]  s_tdata, // quat_w, quat_x, quat_y, quat_z
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [qte_pkg::OUT_TDATA_W-1:0] m_tdata // roll_angle, pitch_angle, yaw_angle
);
	import qte_pkg::*;

	logic fifo_push;
	logic fifo_pop;
	qte_item_t push_data;
	qte_item_t pop_data;
	qte_fifo_st_t fifo_st;

	// Front: accept and classify requests.
	qte_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.fifo_st(fifo_st), .push(fifo_push), .push_data(push_data)
	);

	// Queue between the two halves.
	qte_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(fifo_push), .push_data(push_data),
		.pop(fifo_pop), .pop_data(pop_data), .status(fifo_st)
	);

	// Back: CORDIC lanes and result register.
	qte_back #(.ITER(CORDIC_ITERATIONS), .AF(ANGLE_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.fifo_st(fifo_st), .pop_data(pop_data), .pop(fifo_pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// The front only stalls on a full queue.
	`QTE_ASSERT_IMPL(a_stall_full, !s_tready, fifo_st.full, "front stalled without a full queue")
	// The fill count never exceeds the queue depth.
	`QTE_ASSERT_IMPL(a_cnt_bound, 1'b1, fifo_st.count <= FIFO_CW'(FIFO_DEPTH), "queue overfilled")
	// A held result blocks the back from taking another request.
	`QTE_ASSERT_IMPL(a_hold_nopop, m_tvalid && !m_tready, !fifo_pop, "pop while result held")
	// A full queue that is not drained stays full.
	`QTE_ASSERT_NEXT(a_full_stays, fifo_st.full && !fifo_pop, fifo_st.full, "queue lost a request")
endmodule

// ----- sim/qte_angle_checker.sv -----
// Watches both streams of the quaternion to Euler angle block, predicts each angle set and compares.
`timescale 1ns / 100ps

module qte_angle_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [qte_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [qte_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                              mismatch_count,
	output int                              pending_count
);

	localparam int ITERS = 16;
	localparam int FRAC = 13;
	localparam longint NORM_LIMIT = 64'sd1 << 40;

	typedef struct packed {
		logic [14:0] yaw;
		logic [14:0] pitch;
		logic [14:0] roll;
	} euler_t;

	euler_t expected_angles[$];

	// atan(2^-i) scaled by 2^30.
	function automatic longint atan_step(input int i);
		longint t [0:15] = '{843314857, 497837829, 263043837, 133525159,
			67021687, 33543516, 16775851, 8388437, 4194283, 2097149,
			1048576, 524288, 262144, 131072, 65536, 32768};
		return (i < 16) ? t[i] : (64'sd1 << 30) >>> i;
	endfunction

	function automatic longint iabs(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// Angle of num/den, limited to plus or minus half pi, in FRAC fraction bits.
	function automatic longint cordic_atan(input longint num, input longint den);
		int sh;
		longint hp, cx, cy, dx, dy, acc, r;
		sh = 30 - FRAC;
		hp = (64'sd1686629713 + (64'sd1 << (sh - 1))) >>> sh;
		acc = 0;
		if (den == 0)
			return num > 0 ? hp : (num < 0 ? -hp : 64'sd0);
		cx = iabs(den);
		cy = den < 0 ? -num : num;
		for (int k = 0; k < 64; k++) begin
			if (cx >= NORM_LIMIT || iabs(cy) >= NORM_LIMIT)
				break;
			cx = cx * 2;
			cy = cy * 2;
		end
		for (int i = 0; i < ITERS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx += dx;
				cy -= dy;
				acc += atan_step(i);
			end else begin
				cx -= dx;
				cy += dy;
				acc -= atan_step(i);
			end
		end
		r = (acc + (64'sd1 << (sh - 1))) >>> sh;
		if (r > hp)
			r = hp;
		if (r < -hp)
			r = -hp;
		return r;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned op);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > op)
			b >>= 2;
		while (b != 0) begin
			if (op >= res + b) begin
				op -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic euler_t predict_angles(input logic [63:0] q);
		longint w, x, y, z, one, s, c;
		euler_t e;
		w = longint'($signed(q[15:0]));
		x = longint'($signed(q[31:16]));
		y = longint'($signed(q[47:32]));
		z = longint'($signed(q[63:48]));
		one = 64'sd1 << 28;
		s = -2 * (x * z - y * w);
		if (s > one)
			s = one;
		if (s < -one)
			s = -one;
		c = longint'(int_sqrt(longint'(one * one) - s * s));
		e.roll = 15'(cordic_atan(2 * (y * z + x * w), w * w - x * x - y * y + z * z));
		e.pitch = 15'(cordic_atan(s, c));
		e.yaw = 15'(cordic_atan(2 * (x * y + w * z), w * w + x * x - y * y - z * z));
		return e;
	endfunction

	task automatic report_mismatch(input string what, input logic [14:0] got,
		input logic [14:0] want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, $signed(got),
			$signed(want), $realtime);
		mismatch_count++;
	endtask

	initial mismatch_count = 0;
	assign pending_count = expected_angles.size();

	// Log each accepted request, then compare each accepted result.
	always @(posedge clk) begin
		euler_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_angles.push_back(predict_angles(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[44:0];
				if (expected_angles.size() == 0) begin
					report_mismatch("unexpected result, roll", got.roll, 15'd0);
				end else begin
					want = expected_angles.pop_front();
					if (got.roll !== want.roll)
						report_mismatch("roll", got.roll, want.roll);
					if (got.pitch !== want.pitch)
						report_mismatch("pitch", got.pitch, want.pitch);
					if (got.yaw !== want.yaw)
						report_mismatch("yaw", got.yaw, want.yaw);
				end
			end
		end
	end

endmodule

// ----- sim/tb.sv -----
// Stimulus and verdict for the quaternion to Euler angle block.
`timescale 1ns / 100ps

module tb;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [qte_pkg::IN_TDATA_W-1:0] s_tdata;
	logic [qte_pkg::OUT_TDATA_W-1:0] m_tdata;
	int mismatch_count, pending_count;
	int send_idle_pct, recv_stall_pct, hold_cycles;
	bit hold_req;

	quaternion_to_euler_angles i_dut (.*);

	qte_angle_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off when asked.
	initial begin
		m_tready = 0;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_cycles = 300;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 0;
			end else begin
				m_tready <= $urandom_range(99) >= recv_stall_pct;
			end
		end
	end

	// Offer one quaternion and wait until it is accepted.
	task automatic send_quat(input logic [15:0] w, x, y, z);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {z, y, x, w};
		do @(posedge clk); while (!s_tready);
	endtask

	// Mostly unit quaternions with random direction; some raw bit patterns.
	task automatic send_random_quat();
		real c [4];
		real n;
		if ($urandom_range(99) < 20) begin
			send_quat($urandom, $urandom, $urandom, $urandom);
		end else begin
			n = 0;
			foreach (c[i]) begin
				c[i] = ($urandom_range(65535) - 32767.5) / 32768.0;
				if ($urandom_range(9) == 0)
					c[i] = 0;
				n += c[i] * c[i];
			end
			if (n == 0) begin
				c[0] = 1;
				n = 1;
			end
			n = $sqrt(n);
			send_quat(16'($rtoi(c[0] / n * 16384.0)), 16'($rtoi(c[1] / n * 16384.0)),
				16'($rtoi(c[2] / n * 16384.0)), 16'($rtoi(c[3] / n * 16384.0)));
		end
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		hold_req = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: identity, axes, zero denominators, gimbal lock, saturation.
		send_quat(16384, 0, 0, 0);
		send_quat(-16384, 0, 0, 0);
		send_quat(0, 16384, 0, 0);
		send_quat(0, 0, 16384, 0);
		send_quat(0, 0, 0, 16384);
		send_quat(0, 0, 0, -16384);
		send_quat(0, 0, 0, 0);
		send_quat(11585, 0, 11585, 0);
		send_quat(11585, 0, -11585, 0);
		send_quat(11585, 11585, 0, 0);
		send_quat(11585, 0, 0, 11585);
		send_quat(16384, 0, 16384, 0);
		send_quat(16384, 16384, 0, 0);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_quat(8192, 8192, 8192, 8192);
		send_quat(8192, -8192, 8192, -8192);
		send_quat(1, 0, 0, 0);
		send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);

		// Random phases with different idling patterns.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 70 : (ph == 3) ? 11 : 0;
			recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 11 : 0;
			for (int n = 0; n < 300; n++) begin
				if (ph == 0 && n == 100)
					hold_req = 1;
				send_random_quat();
			end
		end
		s_tvalid <= 0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/qte_pkg.sv
rtl/qte_fifo.sv
rtl/qte_front.sv
rtl/qte_lane.sv
rtl/qte_back.sv
rtl/quaternion_to_euler_angles.sv
sim/qte_angle_checker.sv
sim/tb.sv
